[rtl/eda_pkg.sv]
// ----------------------------------------------------------------------------
// eda_pkg
// Shared constants and controller/datapath command and status types for the
// Euclidean distance accumulator.
// ----------------------------------------------------------------------------
package eda_pkg;

   localparam int FEATURE_WIDTH_DEF = 16;
   localparam int ACC_WIDTH_DEF     = 48;
   localparam int DIST_W            = 24;

   typedef struct packed {
      logic load;       // capture a request and form the difference
      logic square;     // register the square of the difference
      logic accum;      // add the square into the running sum
      logic root_step;  // one digit of the square root
      logic out_load;   // move the finished root into the result register
   } dp_cmd_type;

   typedef struct packed {
      logic last;       // captured request closes the vector
      logic root_last;  // current root step is the final one
   } dp_status_type;

endpackage : eda_pkg

[rtl/eda_if.sv]
// ----------------------------------------------------------------------------
// eda_req_if / eda_rsp_if
// Valid/ready channels for element pairs and distance results.
// ----------------------------------------------------------------------------
interface eda_req_if #(
   parameter int FEATURE_WIDTH = eda_pkg::FEATURE_WIDTH_DEF
);
   logic                            valid;
   logic                            ready;
   logic signed [FEATURE_WIDTH-1:0] elem_a;
   logic signed [FEATURE_WIDTH-1:0] elem_b;
   logic                            last;

   modport source (output valid, output elem_a, output elem_b, output last, input ready);
   modport sink   (input valid, input elem_a, input elem_b, input last, output ready);
endinterface : eda_req_if

interface eda_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [eda_pkg::DIST_W-1:0] distance;
   logic                      saturated;

   modport source (output valid, output distance, output saturated, input ready);
   modport sink   (input valid, input distance, input saturated, output ready);
endinterface : eda_rsp_if

[rtl/eda_ctrl.sv]
// ----------------------------------------------------------------------------
// eda_ctrl
// Sequencer: request capture, square, accumulate, iterative root, result
// hand-off. Owns the channel handshakes.
// ----------------------------------------------------------------------------
module eda_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  eda_pkg::dp_status_type status,
   output eda_pkg::dp_cmd_type    cmd
);
   import eda_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_ACC  = 3'd2;
   localparam logic [2:0] S_ROOT = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.load      = req_ready && req_valid;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.square = 1'b1;
            state_in   = S_ACC;
         end
         S_ACC: begin
            cmd.accum = 1'b1;
            state_in  = status.last ? S_ROOT : S_IDLE;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_last) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // wait here only while the previous result is still unclaimed
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule : eda_ctrl

[rtl/eda_dpath.sv]
// ----------------------------------------------------------------------------
// eda_dpath
// Difference, squarer, saturating accumulator, one-bit-per-cycle square root
// and result register.
// ----------------------------------------------------------------------------
module eda_dpath #(
   parameter int FEATURE_WIDTH = eda_pkg::FEATURE_WIDTH_DEF,
   parameter int ACC_WIDTH     = eda_pkg::ACC_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  eda_pkg::dp_cmd_type             cmd,
   output eda_pkg::dp_status_type          status,
   input  logic signed [FEATURE_WIDTH-1:0] elem_a,
   input  logic signed [FEATURE_WIDTH-1:0] elem_b,
   input  logic                            last,
   output logic [eda_pkg::DIST_W-1:0]      distance,
   output logic                            saturated
);
   import eda_pkg::*;

   localparam int MAG_W  = FEATURE_WIDTH + 1;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int SUM_W  = ((SQ_W > ACC_WIDTH) ? SQ_W : ACC_WIDTH) + 1;
   localparam int ROOT_W = (ACC_WIDTH + 1) / 2;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int CNT_W  = $clog2(ROOT_W);

   logic signed [MAG_W-1:0]  diff_ff;
   logic                     last_ff;
   logic [MAG_W-1:0]         mag;
   logic [SQ_W-1:0]          sq_ff;
   logic [ACC_WIDTH-1:0]     sum_ff, sum_in;
   logic                     sat_ff, sat_in;
   logic [SUM_W-1:0]         total;
   logic                     ovf;
   logic                     res_sat_ff;
   logic [RAD_W-1:0]         rad_ff;
   logic [REM_W-1:0]         rem_ff;
   logic [ROOT_W-1:0]        root_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [REM_W-1:0]         rem_sh, trial;
   logic                     fits;
   logic [DIST_W+ROOT_W-1:0] root_ext;
   logic [DIST_W-1:0]        dist_ff;
   logic                     sat_out_ff;

   // stage 1: signed difference, one bit wider than the elements
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         diff_ff <= MAG_W'(elem_a) - MAG_W'(elem_b);
         last_ff <= last;
      end
   end

   assign mag = diff_ff[MAG_W-1] ? MAG_W'(-diff_ff) : MAG_W'(diff_ff);

   // stage 2: exact square
   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sq_ff <= SQ_W'(mag) * SQ_W'(mag);
      end
   end

   // stage 3: saturating accumulate
   assign total  = SUM_W'(sum_ff) + SUM_W'(sq_ff);
   assign ovf    = |total[SUM_W-1:ACC_WIDTH];
   assign sum_in = ovf ? '1 : total[ACC_WIDTH-1:0];
   assign sat_in = sat_ff | ovf;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         sat_ff <= 1'b0;
      end else if (cmd.accum) begin
         if (last_ff) begin
            sum_ff <= '0;
            sat_ff <= 1'b0;
         end else begin
            sum_ff <= sum_in;
            sat_ff <= sat_in;
         end
      end
   end

   // restoring square root, two radicand bits per step
   assign rem_sh = {rem_ff[ROOT_W-1:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign fits   = (rem_sh >= trial);

   always_ff @(posedge clock) begin
      if (cmd.accum && last_ff) begin
         rad_ff     <= RAD_W'(sum_in);
         rem_ff     <= '0;
         root_ff    <= '0;
         cnt_ff     <= '0;
         res_sat_ff <= sat_in;
      end else if (cmd.root_step) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= fits ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[ROOT_W-2:0], fits};
         cnt_ff  <= cnt_ff + CNT_W'(1);
      end
   end

   assign root_ext = {{DIST_W{1'b0}}, root_ff};

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         dist_ff    <= root_ext[DIST_W-1:0];
         sat_out_ff <= res_sat_ff;
      end
   end

   assign status.last      = last_ff;
   assign status.root_last = (cnt_ff == CNT_W'(ROOT_W - 1));
   assign distance         = dist_ff;
   assign saturated        = sat_out_ff;

endmodule : eda_dpath

[rtl/euclidean_distance_accumulator.sv]
// Each element pair is captured, squared and accumulated in turn; the pair
// marked last then runs the iterative root steps and a result-register load.
// A new pair is taken only after the previous one has been accumulated.
// A finished result waits in its own register while the next vector streams.
// Reset (synchronous, active high) clears the sum, the flag and the handshakes.
// ----------------------------------------------------------------------------
// euclidean_distance_accumulator
// Sum of squared differences of Q8.8 element pairs, floor square root on the
// last pair, saturating accumulator with sticky flag.
// ----------------------------------------------------------------------------
module euclidean_distance_accumulator #(
   parameter int FEATURE_WIDTH = eda_pkg::FEATURE_WIDTH_DEF,
   parameter int ACC_WIDTH     = eda_pkg::ACC_WIDTH_DEF
) (
   input logic   clock,
   input logic   reset,
   eda_req_if.sink   req_chan,
   eda_rsp_if.source rsp_chan
);
   import eda_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   eda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   eda_dpath #(
      .FEATURE_WIDTH (FEATURE_WIDTH),
      .ACC_WIDTH     (ACC_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .elem_a    (req_chan.elem_a),
      .elem_b    (req_chan.elem_b),
      .last      (req_chan.last),
      .distance  (rsp_chan.distance),
      .saturated (rsp_chan.saturated)
   );

`ifndef ASSERT_OFF
   // one request in flight: no new request straight after one is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (!req_chan.ready && cmd.square))
      else $error("request accepted while previous one still in work");

   // the result register is never overwritten while its result is unclaimed
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("pending result overwritten");

   // the root starts right after the last pair is accumulated
   a_root_follows: assert property (@(posedge clock) disable iff (reset)
      (cmd.accum && status.last) |=> cmd.root_step)
      else $error("root did not start after last request");

   // a result appears only through a result-register load
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.out_load))
      else $error("result valid without a result load");
`endif

endmodule : euclidean_distance_accumulator

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Euclidean distance accumulator. Streams Q8.8
// element pairs through the request channel and keeps its own sum of
// squares and sticky saturation flag. On every pair marked last it queues
// the floor root, then compares each result from the response channel.
// ----------------------------------------------------------------------------
module tb;

   import eda_pkg::*;

   localparam int FW        = FEATURE_WIDTH_DEF;
   localparam int AW        = ACC_WIDTH_DEF;
   localparam int DW        = DIST_W;
   localparam int LIMIT     = 1_500_000;
   localparam int TAIL      = AW / 2 + 16;
   localparam int RAND_REQS = 1600;

   localparam logic [64:0] ACC_MAX = (65'd1 << AW) - 65'd1;

   typedef struct {
      logic [DW-1:0] distance;
      logic          saturated;
   } dist_result_t;

   logic clock;
   logic reset;

   eda_req_if #(.FEATURE_WIDTH(FW)) req_if ();
   eda_rsp_if                       rsp_if ();

   euclidean_distance_accumulator #(
      .FEATURE_WIDTH(FW),
      .ACC_WIDTH    (AW)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   logic [AW-1:0] run_sum;
   logic          run_sat;
   dist_result_t  pending_distances[$];
   int            mismatch_count;
   int            cycle_count;
   int            reqs_sent;
   bit            gaps_on;
   bit            stalls_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short idles, now and then a long one.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [63:0] floor_root(input logic [63:0] n);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bitv;
      rem  = n;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         bitv = 64'd1 << (2 * i);
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
      end
      return root;
   endfunction

   task automatic accumulate_pair(input logic signed [FW-1:0] a,
                                  input logic signed [FW-1:0] b,
                                  input logic                 last);
      logic signed [FW:0] diff;
      logic [FW:0]        mag;
      logic [64:0]        sq;
      logic [64:0]        total;
      logic [63:0]        root;
      dist_result_t       res;
      diff  = (FW+1)'(a) - (FW+1)'(b);
      mag   = (diff < 0) ? -diff : diff;
      sq    = 65'(mag) * 65'(mag);
      total = 65'(run_sum) + sq;
      if (total > ACC_MAX) begin
         run_sum = '1;
         run_sat = 1'b1;
      end else begin
         run_sum = total[AW-1:0];
      end
      if (last) begin
         root          = floor_root(64'(run_sum));
         res.distance  = root[DW-1:0];
         res.saturated = run_sat;
         pending_distances.push_back(res);
         run_sum = '0;
         run_sat = 1'b0;
      end
   endtask

   // valid is only dropped when a gap is taken, so back-to-back requests
   // never see it lowered and raised in the same step
   task automatic send_pair(input logic signed [FW-1:0] a,
                            input logic signed [FW-1:0] b,
                            input logic                 last);
      int gap;
      gap = gaps_on ? idle_len() : 0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.elem_a <= a;
      req_if.elem_b <= b;
      req_if.last   <= last;
      do @(posedge clock); while (!req_if.ready);
      accumulate_pair(a, b, last);
      reqs_sent++;
   endtask

   // lowers valid and waits on the clock before it checks the queue, so valid is
   // never lowered and raised in the same step
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_distances.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [FW-1:0] rand_elem();
      logic signed [FW-1:0] v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: v = {1'b1, {(FW-1){1'b0}}};
               1: v = {1'b0, {(FW-1){1'b1}}};
               2: v = '0;
               3: v = '1;
               default: v = FW'(1);
            endcase
         end
         1, 2, 3: v = FW'($signed($urandom_range(0, 511)) - 256);
         default: v = FW'($urandom());
      endcase
      return v;
   endfunction

   task automatic test_directed();
      localparam logic signed [FW-1:0] MAXP = {1'b0, {(FW-1){1'b1}}};
      localparam logic signed [FW-1:0] MAXN = {1'b1, {(FW-1){1'b0}}};
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      send_pair(0, 0, 1'b1);
      send_pair(256, 0, 1'b1);
      send_pair(0, 256, 1'b1);
      send_pair(MAXP, MAXN, 1'b1);
      send_pair(MAXN, MAXP, 1'b1);
      send_pair(MAXN, MAXN, 1'b1);
      send_pair(MAXP, MAXP, 1'b1);
      send_pair(MAXN, 0, 1'b1);
      send_pair(0, MAXN, 1'b1);
      send_pair(1, 0, 1'b1);
      // 3-4-5 triangle scaled: exact root
      send_pair(768, 0, 1'b0);
      send_pair(0, 1024, 1'b0);
      send_pair(0, 0, 1'b1);
      // root of 2, truncated
      send_pair(-1, 0, 1'b0);
      send_pair(0, -1, 1'b1);
      send_pair(2, 0, 1'b0);
      send_pair(0, 1, 1'b0);
      send_pair(-5, -3, 1'b0);
      send_pair(MAXP, MAXN, 1'b0);
      send_pair(MAXN, MAXP, 1'b1);
   endtask

   task automatic test_random();
      int target;
      int len;
      int r;
      int vecs;
      target = reqs_sent + RAND_REQS;
      vecs   = 0;
      while (reqs_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 70) len = $urandom_range(1, 6);
         else if (r < 95) len = $urandom_range(7, 24);
         else len = $urandom_range(25, 64);
         for (int i = 0; i < len; i++) send_pair(rand_elem(), rand_elem(), i == len - 1);
         vecs++;
         if (vecs % 25 == 0) begin
            gaps_on   = $urandom_range(0, 2) != 0;
            stalls_on = $urandom_range(0, 2) != 0;
         end
         if (vecs % 40 == 0) drain_results();
      end
   endtask

   task automatic test_pause();
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      send_pair(512, -512, 1'b0);
      send_pair(-300, 77, 1'b1);
      drain_results();
      send_pair(1000, 1, 1'b1);
      drain_results();
      send_pair(-7, 9, 1'b0);
      send_pair(12, -12, 1'b1);
   endtask

   // response side back-pressure
   int stall_left;
   initial begin
      rsp_if.ready = 1'b0;
      stall_left   = 0;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (stalls_on) stall_left = idle_len();
         end
      end
   end

   always @(posedge clock) begin
      dist_result_t exp_res;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_distances.size() == 0) begin
            $display("%0t: result expected none actual distance %0d saturated %0b",
                     $time, rsp_if.distance, rsp_if.saturated);
            mismatch_count++;
         end else begin
            exp_res = pending_distances.pop_front();
            if (rsp_if.distance !== exp_res.distance) begin
               $display("%0t: distance expected %0d actual %0d", $time,
                        exp_res.distance, rsp_if.distance);
               mismatch_count++;
            end
            if (rsp_if.saturated !== exp_res.saturated) begin
               $display("%0t: saturated expected %0b actual %0b", $time,
                        exp_res.saturated, rsp_if.saturated);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count <= LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.elem_a  = '0;
      req_if.elem_b  = '0;
      req_if.last    = 1'b0;
      run_sum        = '0;
      run_sat        = 1'b0;
      mismatch_count = 0;
      reqs_sent      = 0;
      gaps_on        = 1'b1;
      stalls_on      = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_pause();
      test_random();

      drain_results();
      repeat (TAIL) @(posedge clock);
      if (pending_distances.size() != 0) begin
         $display("%0t: results expected %0d more actual 0", $time,
                  pending_distances.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule : tb
